// ----- src/rau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH_DEF = 32;

    localparam logic [1:0] KIND_REDUCE    = 2'd0;
    localparam logic [1:0] KIND_MUL_WHOLE = 2'd1;
    localparam logic [1:0] KIND_MUL_FRAC  = 2'd2;
    localparam logic [1:0] KIND_ADD       = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_DEN  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
        logic [31:0] whole_number;
    } req_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [31:0] res_den;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WB_N,
        ST_MUL_D,
        ST_WB_D,
        ST_MUL_Q,
        ST_ADD,
        ST_CHECK,
        ST_GCD,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_AN_WN,
        MUL_AN_BN,
        MUL_AN_BD,
        MUL_AD_BD,
        MUL_BN_AD
    } mul_sel_t;

    typedef enum logic [1:0] {
        RES_ZDEN,
        RES_OVF,
        RES_ZERO,
        RES_QUOT
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     n_from_prod;
        logic     d_from_prod;
        logic     n_add_prod;
        logic     gcd_init;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_write;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic       zden;
        logic       ovf;
        logic       n_zero;
        logic [1:0] kind;
        logic       gcd_done;
        logic       div_last;
        logic       out_free;
    } sts_t;

endpackage

// ----- src/rau_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, 32x32 multiplier, binary gcd unit, dual bit-serial
// exact divider and output register.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  rau_pkg::req_t req_data,
    input  rau_pkg::cmd_t cmd,
    output rau_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rau_pkg::rsp_t rsp_data
);

    localparam int          CNT_W = $clog2(WIDTH);
    localparam logic [63:0] LIMIT = (64'd1 << WIDTH) - 64'd1;

    rau_pkg::req_t     req_reg,     req_next;
    logic [63:0]       prod_reg,    prod_next;
    logic [63:0]       n_reg,       n_next;
    logic [63:0]       d_reg,       d_next;
    logic              zden_reg,    zden_next;
    logic              ovf_reg,     ovf_next;
    logic [WIDTH-1:0]  x_reg,       x_next;
    logic [WIDTH-1:0]  y_reg,       y_next;
    logic [WIDTH-1:0]  div_reg,     div_next;
    logic [WIDTH:0]    rem_n_reg,   rem_n_next;
    logic [WIDTH:0]    rem_d_reg,   rem_d_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    rau_pkg::rsp_t     out_reg,     out_next;
    logic              out_valid_reg, out_valid_next;

    logic [31:0]       op_a;
    logic [31:0]       op_b;
    logic [64:0]       sum;
    logic [WIDTH-1:0]  n_w;
    logic [WIDTH-1:0]  d_w;
    logic [WIDTH:0]    sh_n;
    logic [WIDTH:0]    sh_d;
    logic              ge_n;
    logic              ge_d;
    logic              use_b;
    logic              in_zden;
    logic              in_ovf;

    function automatic logic fits(input logic [63:0] v);
        return v <= LIMIT;
    endfunction

    always_comb
    begin
        case (cmd.mul_sel)
            rau_pkg::MUL_AN_WN:
            begin
                op_a = req_reg.a_num;
                op_b = req_reg.whole_number;
            end
            rau_pkg::MUL_AN_BN:
            begin
                op_a = req_reg.a_num;
                op_b = req_reg.b_num;
            end
            rau_pkg::MUL_AN_BD:
            begin
                op_a = req_reg.a_num;
                op_b = req_reg.b_den;
            end
            rau_pkg::MUL_AD_BD:
            begin
                op_a = req_reg.a_den;
                op_b = req_reg.b_den;
            end
            rau_pkg::MUL_BN_AD:
            begin
                op_a = req_reg.b_num;
                op_b = req_reg.a_den;
            end
            default:
            begin
                op_a = req_reg.a_num;
                op_b = req_reg.a_den;
            end
        endcase
    end

    assign sum  = {1'b0, n_reg} + {1'b0, prod_reg};
    assign n_w  = n_reg[WIDTH-1:0];
    assign d_w  = d_reg[WIDTH-1:0];
    assign sh_n = {rem_n_reg[WIDTH-1:0], n_w[WIDTH-1]};
    assign sh_d = {rem_d_reg[WIDTH-1:0], d_w[WIDTH-1]};
    assign ge_n = sh_n >= {1'b0, div_reg};
    assign ge_d = sh_d >= {1'b0, div_reg};

    assign use_b   = (req_data.kind == rau_pkg::KIND_MUL_FRAC)
                  || (req_data.kind == rau_pkg::KIND_ADD);
    assign in_zden = (req_data.a_den == 32'd0) || (use_b && (req_data.b_den == 32'd0));
    assign in_ovf  = !fits(64'(req_data.a_num)) || !fits(64'(req_data.a_den))
                  || (use_b && (!fits(64'(req_data.b_num)) || !fits(64'(req_data.b_den))))
                  || ((req_data.kind == rau_pkg::KIND_MUL_WHOLE)
                      && !fits(64'(req_data.whole_number)));

    always_comb
    begin
        req_next   = req_reg;
        prod_next  = prod_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        zden_next  = zden_reg;
        ovf_next   = ovf_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        div_next   = div_reg;
        rem_n_next = rem_n_reg;
        rem_d_next = rem_d_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;

        if (cmd.load)
        begin
            req_next  = req_data;
            n_next    = 64'(req_data.a_num);
            d_next    = 64'(req_data.a_den);
            zden_next = in_zden;
            ovf_next  = in_ovf;
        end

        if (cmd.mul_en)
        begin
            prod_next = {32'd0, op_a} * {32'd0, op_b};
        end

        if (cmd.n_from_prod)
        begin
            n_next   = prod_reg;
            ovf_next = ovf_reg | !fits(prod_reg);
        end

        if (cmd.d_from_prod)
        begin
            d_next   = prod_reg;
            ovf_next = ovf_reg | !fits(prod_reg);
        end

        if (cmd.n_add_prod)
        begin
            n_next   = sum[63:0];
            ovf_next = ovf_reg | !fits(prod_reg) | sum[64] | !fits(sum[63:0]);
        end

        if (cmd.gcd_init)
        begin
            x_next = n_w;
            y_next = d_w;
        end

        // Stein step; common factors of two are stripped from n and d too
        if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                n_next = n_reg >> 1;
                d_next = d_reg >> 1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg > y_reg)
            begin
                x_next = (x_reg - y_reg) >> 1;
            end
            else
            begin
                y_next = (y_reg - x_reg) >> 1;
            end
        end

        if (cmd.div_init)
        begin
            div_next   = x_reg;
            rem_n_next = '0;
            rem_d_next = '0;
            cnt_next   = '0;
        end

        if (cmd.div_step)
        begin
            rem_n_next = ge_n ? (sh_n - {1'b0, div_reg}) : sh_n;
            rem_d_next = ge_d ? (sh_d - {1'b0, div_reg}) : sh_d;
            n_next     = 64'({n_w[WIDTH-2:0], ge_n});
            d_next     = 64'({d_w[WIDTH-2:0], ge_d});
            cnt_next   = cnt_reg + CNT_W'(1);
        end

        if (cmd.out_write)
        begin
            out_next.res_num = 32'd0;
            out_next.res_den = 32'd1;
            case (cmd.res_sel)
                rau_pkg::RES_ZDEN: out_next.status = rau_pkg::STAT_ZERO_DEN;
                rau_pkg::RES_OVF:  out_next.status = rau_pkg::STAT_OVERFLOW;
                rau_pkg::RES_ZERO: out_next.status = rau_pkg::STAT_OK;
                rau_pkg::RES_QUOT:
                begin
                    if ((|n_reg[63:32]) || (|d_reg[63:32]))
                    begin
                        out_next.status = rau_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        out_next.res_num = n_reg[31:0];
                        out_next.res_den = d_reg[31:0];
                        out_next.status  = rau_pkg::STAT_OK;
                    end
                end
                default: out_next.status = rau_pkg::STAT_OVERFLOW;
            endcase
        end
    end

    always_comb
    begin
        if (cmd.out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        prod_reg  <= prod_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        zden_reg  <= zden_next;
        ovf_reg   <= ovf_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        div_reg   <= div_next;
        rem_n_reg <= rem_n_next;
        rem_d_reg <= rem_d_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
    end

    assign sts.zden     = zden_reg;
    assign sts.ovf      = ovf_reg;
    assign sts.n_zero   = (n_reg == 64'd0);
    assign sts.kind     = req_reg.kind;
    assign sts.gcd_done = (x_reg == y_reg);
    assign sts.div_last = (cnt_reg == CNT_W'(WIDTH - 1));
    assign sts.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> (x_reg != '0) && (y_reg != '0))
        else $error("gcd step on zero operand");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_n_reg < {1'b0, div_reg}) && (rem_d_reg < {1'b0, div_reg}))
        else $error("divider remainder out of range");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != rau_pkg::STAT_OK))
            |-> (out_reg.res_num == 32'd0) && (out_reg.res_den == 32'd1))
        else $error("error beat without 0/1 result");

endmodule

// ----- src/rau_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply steps, overflow checks, gcd loop, divide loop, output.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output rau_pkg::cmd_t cmd,
    input  rau_pkg::sts_t sts
);

    rau_pkg::state_t   state_reg, state_next;
    rau_pkg::res_sel_t res_reg,   res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::ST_IDLE;
            res_reg   <= rau_pkg::RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        cmd         = '0;
        cmd.mul_sel = rau_pkg::MUL_AN_WN;
        cmd.res_sel = res_reg;
        req_ready   = 1'b0;

        case (state_reg)
            rau_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rau_pkg::ST_DISPATCH;
                end
            end
            rau_pkg::ST_DISPATCH:
            begin
                if (sts.zden)
                begin
                    res_next   = rau_pkg::RES_ZDEN;
                    state_next = rau_pkg::ST_FINISH;
                end
                else if (sts.ovf)
                begin
                    res_next   = rau_pkg::RES_OVF;
                    state_next = rau_pkg::ST_FINISH;
                end
                else
                begin
                    case (sts.kind)
                        rau_pkg::KIND_REDUCE:
                        begin
                            state_next = rau_pkg::ST_CHECK;
                        end
                        rau_pkg::KIND_MUL_WHOLE:
                        begin
                            cmd.mul_en  = 1'b1;
                            cmd.mul_sel = rau_pkg::MUL_AN_WN;
                            state_next  = rau_pkg::ST_WB_N;
                        end
                        rau_pkg::KIND_MUL_FRAC:
                        begin
                            cmd.mul_en  = 1'b1;
                            cmd.mul_sel = rau_pkg::MUL_AN_BN;
                            state_next  = rau_pkg::ST_MUL_D;
                        end
                        default:
                        begin
                            cmd.mul_en  = 1'b1;
                            cmd.mul_sel = rau_pkg::MUL_AN_BD;
                            state_next  = rau_pkg::ST_MUL_D;
                        end
                    endcase
                end
            end
            rau_pkg::ST_WB_N:
            begin
                cmd.n_from_prod = 1'b1;
                state_next      = rau_pkg::ST_CHECK;
            end
            rau_pkg::ST_MUL_D:
            begin
                cmd.n_from_prod = 1'b1;
                cmd.mul_en      = 1'b1;
                cmd.mul_sel     = rau_pkg::MUL_AD_BD;
                if (sts.kind == rau_pkg::KIND_ADD)
                begin
                    state_next = rau_pkg::ST_MUL_Q;
                end
                else
                begin
                    state_next = rau_pkg::ST_WB_D;
                end
            end
            rau_pkg::ST_WB_D:
            begin
                cmd.d_from_prod = 1'b1;
                state_next      = rau_pkg::ST_CHECK;
            end
            rau_pkg::ST_MUL_Q:
            begin
                cmd.d_from_prod = 1'b1;
                cmd.mul_en      = 1'b1;
                cmd.mul_sel     = rau_pkg::MUL_BN_AD;
                state_next      = rau_pkg::ST_ADD;
            end
            rau_pkg::ST_ADD:
            begin
                cmd.n_add_prod = 1'b1;
                state_next     = rau_pkg::ST_CHECK;
            end
            rau_pkg::ST_CHECK:
            begin
                if (sts.ovf)
                begin
                    res_next   = rau_pkg::RES_OVF;
                    state_next = rau_pkg::ST_FINISH;
                end
                else if (sts.n_zero)
                begin
                    res_next   = rau_pkg::RES_ZERO;
                    state_next = rau_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = rau_pkg::ST_GCD;
                end
            end
            rau_pkg::ST_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = rau_pkg::ST_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            rau_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    res_next   = rau_pkg::RES_QUOT;
                    state_next = rau_pkg::ST_FINISH;
                end
            end
            rau_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = rau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write |-> sts.out_free)
        else $error("result written over a pending beat");

    a_n_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.n_from_prod, cmd.n_add_prod, cmd.gcd_step, cmd.div_step}))
        else $error("numerator register driven by two commands");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rau_pkg::ST_DIV && sts.div_last)
            |=> (state_reg == rau_pkg::ST_FINISH) && (res_reg == rau_pkg::RES_QUOT))
        else $error("divider exit missed");

endmodule

// ----- src/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Reduce, scale, multiply or add unsigned fractions; result in lowest terms.
// ----------------------------------------------------------------------------
// One item is processed at a time; a new request beat is taken while the
// previous result beat waits on rsp_ready. An item that fails the zero
// denominator or operand range check goes from dispatch straight to the
// finish state. Otherwise setup runs one 32x32 multiply per cycle, up to
// three multiplies for an add, then the binary gcd loop runs one step per
// cycle, at most 2*WIDTH steps, then a bit-serial exact divider reduces
// numerator and denominator together, and the result is written to the
// output register once a stalled result beat there has gone; a zero
// numerator skips gcd and divide.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rau_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rau_pkg::rsp_t rsp_data
);

    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rau_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

// ----- tb/rau_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_result_checker
// Watches the request and response channels of the rational arithmetic unit.
// For each request beat it computes the reduced fraction and status the unit
// must return, queues it, and compares every response beat in order with the
// oldest queued result. It reports mismatches and the number still waiting.
// ----------------------------------------------------------------------------
module rau_result_checker
    import rau_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_ready,
    input  req_t  req_data,
    input  logic  rsp_valid,
    input  logic  rsp_ready,
    input  rsp_t  rsp_data,
    output int    mismatches,
    output int    outstanding,
    output int    checked,
    output int    ok_count,
    output int    zero_den_count,
    output int    overflow_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        req_t op;
        rsp_t want;
    } awaited_t;

    awaited_t awaiting_results[$];

    function automatic rsp_t rational_result(input req_t op);
        rsp_t        r;
        logic [63:0] lim;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic        use_b;
        logic        ovf;
        lim       = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
        r.res_num = '0;
        r.res_den = 32'd1;
        r.status  = STAT_OK;
        use_b     = (op.kind == KIND_MUL_FRAC) || (op.kind == KIND_ADD);
        n         = '0;
        d         = 64'd1;

        if (op.a_den == '0 || (use_b && op.b_den == '0)) begin
            r.status = STAT_ZERO_DEN;
            return r;
        end

        ovf = (64'(op.a_num) > lim) || (64'(op.a_den) > lim);
        if (use_b && ((64'(op.b_num) > lim) || (64'(op.b_den) > lim)))
            ovf = 1'b1;
        if (op.kind == KIND_MUL_WHOLE && 64'(op.whole_number) > lim)
            ovf = 1'b1;

        if (!ovf) begin
            case (op.kind)
                KIND_REDUCE: begin
                    n = 64'(op.a_num);
                    d = 64'(op.a_den);
                end
                KIND_MUL_WHOLE: begin
                    n = 64'(op.a_num) * 64'(op.whole_number);
                    d = 64'(op.a_den);
                end
                KIND_MUL_FRAC: begin
                    n = 64'(op.a_num) * 64'(op.b_num);
                    d = 64'(op.a_den) * 64'(op.b_den);
                end
                default: begin
                    p = 64'(op.a_num) * 64'(op.b_den);
                    q = 64'(op.b_num) * 64'(op.a_den);
                    d = 64'(op.a_den) * 64'(op.b_den);
                    if (p > lim || q > lim)
                        ovf = 1'b1;
                    n = p + q;
                    if (n < p)
                        ovf = 1'b1;
                end
            endcase
            if (n > lim || d > lim)
                ovf = 1'b1;
        end

        if (ovf) begin
            r.status = STAT_OVERFLOW;
            return r;
        end

        if (n == '0)
            return r;

        x = n;
        y = d;
        while (y != '0) begin
            t = x % y;
            x = y;
            y = t;
        end
        n = n / x;
        d = d / x;

        if (n > 64'hFFFF_FFFF || d > 64'hFFFF_FFFF) begin
            r.status = STAT_OVERFLOW;
            return r;
        end

        r.res_num = n[31:0];
        r.res_den = d[31:0];
        return r;
    endfunction

    initial begin
        mismatches     = 0;
        outstanding    = 0;
        checked        = 0;
        ok_count       = 0;
        zero_den_count = 0;
        overflow_count = 0;
    end

    always @(posedge clk) begin
        awaited_t entry;
        if (rst_n) begin
            if (req_valid && req_ready) begin
                entry.op   = req_data;
                entry.want = rational_result(req_data);
                awaiting_results.push_back(entry);
                case (entry.want.status)
                    STAT_OK:       ok_count++;
                    STAT_ZERO_DEN: zero_den_count++;
                    default:       overflow_count++;
                endcase
            end

            if (rsp_valid && rsp_ready) begin
                if (awaiting_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch %0d at %0t: response beat %0d/%0d st %0d, none due",
                                 mismatches, $time, rsp_data.res_num, rsp_data.res_den,
                                 rsp_data.status);
                end else begin
                    entry = awaiting_results.pop_front();
                    checked++;
                    if (rsp_data.res_num !== entry.want.res_num ||
                        rsp_data.res_den !== entry.want.res_den ||
                        rsp_data.status  !== entry.want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"mismatch %0d at %0t: kind %0d a %0d/%0d b %0d/%0d ",
                                      "w %0d: expected %0d/%0d st %0d, got %0d/%0d st %0d"},
                                     mismatches, $time, entry.op.kind, entry.op.a_num,
                                     entry.op.a_den, entry.op.b_num, entry.op.b_den,
                                     entry.op.whole_number, entry.want.res_num,
                                     entry.want.res_den, entry.want.status,
                                     rsp_data.res_num, rsp_data.res_den, rsp_data.status);
                    end
                end
            end
            outstanding = awaiting_results.size();
        end
    end

endmodule

// ----- tb/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives directed corner cases and then random requests (mostly operands that
// reduce cleanly, plus full-range noise and zero denominators) into the unit,
// with random gaps on the request side and random stalls on the response side.
// A checker beside the unit predicts and compares each response beat.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

    localparam int WIDTH        = rau_pkg::WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 3 * WIDTH + 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 37;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    rau_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    rau_pkg::rsp_t rsp_data;

    int   mismatches;
    int   outstanding;
    int   checked;
    int   ok_count;
    int   zero_den_count;
    int   overflow_count;
    int   sent_count;
    int   cycle_count = 0;
    bit   steady;

    rational_arithmetic_unit #(
        .WIDTH (WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    rau_result_checker #(
        .WIDTH (WIDTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked),
        .ok_count       (ok_count),
        .zero_den_count (zero_den_count),
        .overflow_count (overflow_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
        rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    function automatic rau_pkg::req_t mk_req(input logic [1:0] kind, input logic [31:0] an,
                                             input logic [31:0] ad, input logic [31:0] bn,
                                             input logic [31:0] bd, input logic [31:0] wn);
        rau_pkg::req_t op;
        op.kind         = kind;
        op.a_num        = an;
        op.a_den        = ad;
        op.b_num        = bn;
        op.b_den        = bd;
        op.whole_number = wn;
        return op;
    endfunction

    // uniform value of random bit length 0..maxb
    function automatic logic [31:0] rand_bits(input int unsigned maxb);
        int unsigned b;
        b = $urandom_range(maxb, 0);
        return (b == 0) ? 32'd0 : ($urandom >> (32 - b));
    endfunction

    task automatic send_request(input rau_pkg::req_t op);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= op;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    initial
    begin
        rau_pkg::req_t corner_cases[$];
        rau_pkg::req_t op;
        int            roll;
        logic [31:0]   f;

        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        steady      = 1'b0;
        sent_count  = 0;

        // reduce: repeated factors, zero numerator, full range, zero denominator
        corner_cases.push_back(mk_req(rau_pkg::KIND_REDUCE, 32'd8, 32'd12, '0, '0, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_REDUCE, 32'd1024, 32'd4096, '0, '0, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_REDUCE, 32'd0, 32'd5, '1, '1, '1));
        corner_cases.push_back(mk_req(rau_pkg::KIND_REDUCE, '1, '1, '0, '0, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_REDUCE, 32'd5, 32'd0, '1, '1, '1));
        corner_cases.push_back(mk_req(rau_pkg::KIND_REDUCE, 32'd6, 32'd9, '1, 32'd0, '1));
        // scale by whole number
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_WHOLE, 32'd3, 32'd4, '0, '0, 32'd8));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_WHOLE, '1, 32'd1, '0, '0, 32'd2));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_WHOLE, 32'd5, 32'd7, '1, '1, 32'd0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_WHOLE, 32'd5, 32'd0, '0, '0, 32'd3));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_WHOLE, 32'd1, '1, '1, 32'd0, '1));
        // fraction product
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_FRAC, 32'd2, 32'd3, 32'd9, 32'd4,
                                      '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_FRAC, 32'd1, 32'd65536, 32'd1,
                                      32'd65536, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_FRAC, 32'd2, 32'd3, 32'd9, 32'd0,
                                      '1));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_FRAC, 32'd0, '1, '1, '1, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_MUL_FRAC, 32'd65535, 32'd65536,
                                      32'd65536, 32'd65535, '0));
        // sum, including unity operands, product and sum overflow
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'd1, 32'd1, 32'd1, 32'd1, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'd1, 32'd6, 32'd1, 32'd3, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'd0, 32'd5, 32'd0, 32'd7, '1));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'h8000_0000, 32'd1,
                                      32'h8000_0000, 32'd1, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, '1, 32'd1, 32'd1, 32'd2, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd0, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'd1, '1, 32'd0, 32'd1, '0));
        corner_cases.push_back(mk_req(rau_pkg::KIND_ADD, 32'd3, 32'd4, 32'd1, 32'd0, '0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (corner_cases[i])
            send_request(corner_cases[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady          = (i >= 400 && i < 650);
            roll            = $urandom_range(99);
            op.kind         = 2'($urandom_range(3));
            op.a_num        = $urandom;
            op.a_den        = $urandom;
            op.b_num        = $urandom;
            op.b_den        = $urandom;
            op.whole_number = $urandom;
            if (roll >= 15)
            begin
                f = rand_bits(11) + 32'd1;
                case (op.kind)
                    rau_pkg::KIND_REDUCE:
                    begin
                        op.a_num = rand_bits(20) * f;
                        op.a_den = (rand_bits(20) + 32'd1) * f;
                    end
                    rau_pkg::KIND_MUL_WHOLE:
                    begin
                        op.a_num        = rand_bits(16);
                        op.a_den        = rand_bits(16) + 32'd1;
                        op.whole_number = rand_bits(17);
                    end
                    default:
                    begin
                        op.a_num = rand_bits(16);
                        op.a_den = rand_bits(16) + 32'd1;
                        op.b_num = rand_bits(16);
                        op.b_den = rand_bits(16) + 32'd1;
                    end
                endcase
                if (roll < 22)
                begin
                    case ($urandom_range(2))
                        0:       op.a_den = '0;
                        1:       op.b_den = '0;
                        default:
                        begin
                            op.a_den = '0;
                            op.b_den = '0;
                        end
                    endcase
                end
            end
            send_request(op);
        end
        steady    = 1'b0;
        req_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests (%0d corner cases), checked %0d results",
                 sent_count, corner_cases.size(), checked);
        $display("expected status mix: ok %0d, zero denominator %0d, overflow %0d",
                 ok_count, zero_den_count, overflow_count);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
src/rau_pkg.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit.sv
tb/rau_result_checker.sv
tb/rational_arithmetic_unit_tb.sv
